### sv/signed_int_to_radix_text_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the radix text converter
// Shared property forms; every use sits on a line of its own.
// ---------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_RADIX_TEXT_MACROS_SVH
`define SIGNED_INT_TO_RADIX_TEXT_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high
`define SITRT_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high
`define SITRT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/sitrt_pkg.sv
// ---------------------------------------------------------------------------
// sitrt_pkg
// Widths, character codes, status structs and symbol lookup for the
// radix text converter.
// ---------------------------------------------------------------------------
package sitrt_pkg;

   localparam int NUMBER_WIDTH = 32;
   localparam int MAG_WIDTH    = NUMBER_WIDTH + 1;
   localparam int MAX_BASE     = 16;
   localparam int BASE_W       = 5;
   localparam int SYM_IDX_W    = $clog2(MAX_BASE);
   localparam int CHAR_W       = 8;
   localparam int SYM_BITS     = MAX_BASE * CHAR_W;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_ADDR_W   = 2;

   // Divider: STEP_BITS quotient bits per cycle
   localparam int STEP_BITS    = 4;
   localparam int DIV_STEPS    = (MAG_WIDTH + STEP_BITS - 1) / STEP_BITS;
   localparam int SHREG_W      = DIV_STEPS * STEP_BITS;
   localparam int STEP_CNT_W   = $clog2(DIV_STEPS);

   // Digit stack
   localparam int MAX_DIGITS   = MAG_WIDTH;
   localparam int DIG_ADDR_W   = $clog2(MAX_DIGITS);
   localparam int DIG_CNT_W    = $clog2(MAX_DIGITS + 1);

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_BASE_LEN     = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SYMBOLS_LOW  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SYMBOLS_HIGH = 2'd2;

   // Character codes
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   typedef struct packed {
      logic done;
      logic ok;
   } chk_status_type;

   typedef struct packed {
      logic                 done;
      logic                 more;
      logic [SYM_IDX_W-1:0] digit;
   } div_status_type;

   function automatic logic [CHAR_W-1:0] symbol_at(input logic [SYM_BITS-1:0]  syms,
                                                   input logic [SYM_IDX_W-1:0] idx);
      return syms[idx*CHAR_W +: CHAR_W];
   endfunction

endpackage

### sv/sitrt_alpha_chk.sv
// ---------------------------------------------------------------------------
// sitrt_alpha_chk
// Alphabet scan: one symbol row per cycle against the symbols above it.
// ---------------------------------------------------------------------------
module sitrt_alpha_chk (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [sitrt_pkg::BASE_W-1:0]          base_len,
   input  logic [sitrt_pkg::SYM_BITS-1:0]        symbols,
   output sitrt_pkg::chk_status_type             status
);

   logic                                busy_ff;
   logic                                done_ff;
   logic                                bad_ff;
   logic                                bad_in;
   logic [sitrt_pkg::SYM_IDX_W-1:0]     idx_ff;
   logic [sitrt_pkg::SYM_BITS-1:0]      sym_sr_ff;
   logic [sitrt_pkg::CHAR_W-1:0]        cur_sym;
   logic                                row_bad;
   logic                                len_bad;

   assign cur_sym = sym_sr_ff[sitrt_pkg::CHAR_W-1:0];
   assign len_bad = (base_len < sitrt_pkg::BASE_W'(2)) ||
                    (base_len > sitrt_pkg::BASE_W'(sitrt_pkg::MAX_BASE));

   // Row idx: current symbol sits in byte 0, symbol idx+k in byte k
   always_comb begin
      logic [sitrt_pkg::BASE_W-1:0] pos;
      row_bad = 1'b0;
      pos     = '0;
      if ({1'b0, idx_ff} < base_len) begin
         if (cur_sym == sitrt_pkg::CHAR_NUL || cur_sym == sitrt_pkg::CHAR_PLUS ||
             cur_sym == sitrt_pkg::CHAR_MINUS) begin
            row_bad = 1'b1;
         end
         for (int k = 1; k < sitrt_pkg::MAX_BASE; k++) begin
            pos = {1'b0, idx_ff} + sitrt_pkg::BASE_W'(k);
            if (pos < base_len &&
                sym_sr_ff[k*sitrt_pkg::CHAR_W +: sitrt_pkg::CHAR_W] == cur_sym) begin
               row_bad = 1'b1;
            end
         end
      end
   end

   assign bad_in = bad_ff | row_bad;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         bad_ff  <= 1'b0;
      end else if (start) begin
         busy_ff   <= 1'b1;
         done_ff   <= 1'b0;
         bad_ff    <= len_bad;
         idx_ff    <= '0;
         sym_sr_ff <= symbols;
      end else if (busy_ff) begin
         bad_ff    <= bad_in;
         sym_sr_ff <= sym_sr_ff >> sitrt_pkg::CHAR_W;
         idx_ff    <= idx_ff + 1'b1;
         if (idx_ff == sitrt_pkg::SYM_IDX_W'(sitrt_pkg::MAX_BASE - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign status.done = done_ff;
   assign status.ok   = done_ff & ~bad_ff;

endmodule

### sv/sitrt_div_unit.sv
// ---------------------------------------------------------------------------
// sitrt_div_unit
// Digit-serial divider: the magnitude circulates through a shift register,
// STEP_BITS quotient bits per cycle, one radix digit per full pass.
// ---------------------------------------------------------------------------
module sitrt_div_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  logic                                  cont,
   input  logic [sitrt_pkg::MAG_WIDTH-1:0]       mag,
   input  logic [sitrt_pkg::BASE_W-1:0]          divisor,
   output sitrt_pkg::div_status_type             status
);

   logic                                 busy_ff;
   logic [sitrt_pkg::STEP_CNT_W-1:0]     cnt_ff;
   logic [sitrt_pkg::BASE_W-1:0]         rem_ff;
   logic [sitrt_pkg::BASE_W-1:0]         rem_in;
   logic                                 nz_ff;
   logic [sitrt_pkg::SHREG_W-1:0]        shreg_ff;
   logic [sitrt_pkg::STEP_BITS-1:0]      quo_in;
   logic                                 last_step;

   // Restoring division over the top STEP_BITS bits, MSB first
   always_comb begin
      logic [sitrt_pkg::BASE_W:0] trial;
      rem_in = rem_ff;
      quo_in = '0;
      trial  = '0;
      for (int b = sitrt_pkg::STEP_BITS - 1; b >= 0; b--) begin
         trial = {rem_in, shreg_ff[sitrt_pkg::SHREG_W - sitrt_pkg::STEP_BITS + b]};
         if (trial >= {1'b0, divisor}) begin
            quo_in[b] = 1'b1;
            rem_in    = sitrt_pkg::BASE_W'(trial - {1'b0, divisor});
         end else begin
            rem_in    = trial[sitrt_pkg::BASE_W-1:0];
         end
      end
   end

   assign last_step = busy_ff && (cnt_ff == sitrt_pkg::STEP_CNT_W'(sitrt_pkg::DIV_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         rem_ff  <= '0;
         nz_ff   <= 1'b0;
      end else if (load) begin
         busy_ff  <= 1'b1;
         cnt_ff   <= '0;
         rem_ff   <= '0;
         nz_ff    <= 1'b0;
         shreg_ff <= sitrt_pkg::SHREG_W'(mag);
      end else if (busy_ff) begin
         shreg_ff <= {shreg_ff[sitrt_pkg::SHREG_W-sitrt_pkg::STEP_BITS-1:0], quo_in};
         if (last_step) begin
            // Quotient now fills the register; restart for the next digit if cont is set
            busy_ff <= cont;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            nz_ff   <= 1'b0;
         end else begin
            cnt_ff  <= cnt_ff + 1'b1;
            rem_ff  <= rem_in;
            nz_ff   <= nz_ff | (quo_in != '0);
         end
      end
   end

   assign status.done  = last_step;
   assign status.digit = rem_in[sitrt_pkg::SYM_IDX_W-1:0];
   assign status.more  = nz_ff | (quo_in != '0);

endmodule

### sv/sitrt_digit_stack.sv
// ---------------------------------------------------------------------------
// sitrt_digit_stack
// Digit store: written least significant first, read back in reverse.
// ---------------------------------------------------------------------------
module sitrt_digit_stack (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [sitrt_pkg::DIG_ADDR_W-1:0]      wr_addr,
   input  logic [sitrt_pkg::SYM_IDX_W-1:0]       wr_data,
   input  logic [sitrt_pkg::DIG_ADDR_W-1:0]      rd_addr,
   output logic [sitrt_pkg::SYM_IDX_W-1:0]       rd_data
);

   logic [sitrt_pkg::SYM_IDX_W-1:0] mem [sitrt_pkg::MAX_DIGITS];
   logic [sitrt_pkg::SYM_IDX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/signed_int_to_radix_text.sv
// Converts one signed 32-bit request into text in a radix set by the
// configured alphabet: an optional '-' and then the digit symbols, most
// significant first, one byte per response beat, with rsp_tlast on the final
// byte. Zero gives one digit and the most negative value converts correctly.
// If base_len is below 2 or above 16, or a used symbol is NUL, '+' or '-', or
// two used symbols repeat, the request is consumed and nothing is emitted.
// One request is in flight at a time. A request with D digits (1 to 32 for a
// valid alphabet) is accepted, then takes one pass of the shared divider
// per digit (4 quotient bits per cycle over a 36-bit circulating word),
// then waits in the check state for the alphabet verdict (the scan started
// at accept must finish first), then a handshake for the sign, if any, and
// for each digit a stack read, an output load and a handshake that the sink
// can stall. A rejected request holds the block until its division and scan
// finish. Write configuration only while no request is in progress.
// ---------------------------------------------------------------------------
// signed_int_to_radix_text
// Signed integer to radix text converter, top level.
// ---------------------------------------------------------------------------
`include "signed_int_to_radix_text_macros.svh"

module signed_int_to_radix_text (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic signed [sitrt_pkg::NUMBER_WIDTH-1:0] req_tdata,  // [31:0] number
   // response channel
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [sitrt_pkg::CHAR_W-1:0]           rsp_tdata,   // [7:0] text_byte
   output logic                                   rsp_tlast,
   // configuration write port
   input  logic                                   csr_wr_en,
   input  logic [sitrt_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [sitrt_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_CHECK,
      ST_FETCH,
      ST_SHOW,
      ST_OUT
   } state_type;

   // Configuration registers
   logic [sitrt_pkg::BASE_W-1:0]       base_len_ff;
   logic [sitrt_pkg::CSR_DATA_W-1:0]   symbols_low_ff;
   logic [sitrt_pkg::CSR_DATA_W-1:0]   symbols_high_ff;
   logic [sitrt_pkg::SYM_BITS-1:0]     symbols;

   // Control
   state_type                          state_ff;
   logic                               neg_ff;
   logic                               sign_ff;
   logic [sitrt_pkg::DIG_CNT_W-1:0]    ndig_ff;
   logic [sitrt_pkg::DIG_ADDR_W-1:0]   ptr_ff;
   logic                               rsp_valid_ff;
   logic [sitrt_pkg::CHAR_W-1:0]       rsp_data_ff;
   logic                               rsp_last_ff;

   logic                               req_accept;
   logic [sitrt_pkg::MAG_WIDTH-1:0]    sext;
   logic [sitrt_pkg::MAG_WIDTH-1:0]    mag;
   logic                               div_cont;
   logic [sitrt_pkg::SYM_IDX_W-1:0]    rd_digit;

   sitrt_pkg::chk_status_type          chk_stat;
   sitrt_pkg::div_status_type          div_stat;

   assign symbols = {symbols_high_ff, symbols_low_ff};

   // Configuration writes; other indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         base_len_ff     <= '0;
         symbols_low_ff  <= '0;
         symbols_high_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_addr)
            sitrt_pkg::CSR_BASE_LEN: begin
               base_len_ff <= csr_wdata[sitrt_pkg::BASE_W-1:0];
            end
            sitrt_pkg::CSR_SYMBOLS_LOW: begin
               symbols_low_ff <= csr_wdata;
            end
            sitrt_pkg::CSR_SYMBOLS_HIGH: begin
               symbols_high_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // Magnitude one bit wider than the number, so the most negative value fits
   assign sext = {req_tdata[sitrt_pkg::NUMBER_WIDTH-1], req_tdata};
   assign mag  = req_tdata[sitrt_pkg::NUMBER_WIDTH-1] ? (~sext + 1'b1) : sext;

   // Keep dividing while the quotient is nonzero and the stack has room
   assign div_cont = div_stat.done && div_stat.more &&
                     (ndig_ff < sitrt_pkg::DIG_CNT_W'(sitrt_pkg::MAX_DIGITS - 1));

   sitrt_alpha_chk u_chk (
      .clock    (clock),
      .reset    (reset),
      .start    (req_accept),
      .base_len (base_len_ff),
      .symbols  (symbols),
      .status   (chk_stat)
   );

   sitrt_div_unit u_div (
      .clock    (clock),
      .reset    (reset),
      .load     (req_accept),
      .cont     (div_cont),
      .mag      (mag),
      .divisor  (base_len_ff),
      .status   (div_stat)
   );

   sitrt_digit_stack u_stack (
      .clock    (clock),
      .wr_en    (div_stat.done),
      .wr_addr  (ndig_ff[sitrt_pkg::DIG_ADDR_W-1:0]),
      .wr_data  (div_stat.digit),
      .rd_addr  (ptr_ff),
      .rd_data  (rd_digit)
   );

   // Sequencer: divide, wait for the alphabet verdict, then emit, or drop the request on a bad alphabet
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         neg_ff       <= 1'b0;
         sign_ff      <= 1'b0;
         ndig_ff      <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  neg_ff   <= req_tdata[sitrt_pkg::NUMBER_WIDTH-1];
                  ndig_ff  <= '0;
                  state_ff <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               if (div_stat.done) begin
                  ndig_ff <= ndig_ff + 1'b1;
                  if (!div_cont) begin
                     state_ff <= ST_CHECK;
                  end
               end
            end
            ST_CHECK: begin
               // Point at the most significant digit
               ptr_ff <= sitrt_pkg::DIG_ADDR_W'(ndig_ff - 1'b1);
               if (chk_stat.done) begin
                  if (!chk_stat.ok) begin
                     state_ff <= ST_IDLE;
                  end else if (neg_ff) begin
                     rsp_data_ff  <= sitrt_pkg::CHAR_MINUS;
                     rsp_last_ff  <= 1'b0;
                     rsp_valid_ff <= 1'b1;
                     sign_ff      <= 1'b1;
                     state_ff     <= ST_OUT;
                  end else begin
                     state_ff <= ST_FETCH;
                  end
               end
            end
            ST_FETCH: begin
               // Stack read data lands at the end of this cycle
               state_ff <= ST_SHOW;
            end
            ST_SHOW: begin
               rsp_data_ff  <= sitrt_pkg::symbol_at(symbols, rd_digit);
               rsp_last_ff  <= (ptr_ff == '0);
               rsp_valid_ff <= 1'b1;
               sign_ff      <= 1'b0;
               state_ff     <= ST_OUT;
            end
            ST_OUT: begin
               if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_last_ff) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     // The sign does not use a stack entry
                     if (!sign_ff) begin
                        ptr_ff <= ptr_ff - 1'b1;
                     end
                     sign_ff  <= 1'b0;
                     state_ff <= ST_FETCH;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `SITRT_ASSERT_IMPL(a_emit_needs_ok, rsp_valid_ff, chk_stat.ok,
      "response without valid alphabet")
   `SITRT_ASSERT_IMPL(a_digit_cap, 1'b1,
      ndig_ff <= sitrt_pkg::DIG_CNT_W'(sitrt_pkg::MAX_DIGITS), "digit count overflow")
   `SITRT_ASSERT_IMPL(a_digit_in_divide, div_stat.done, state_ff == ST_DIVIDE,
      "digit outside divide phase")
   `SITRT_ASSERT_NEXT(a_last_ends, rsp_tvalid && rsp_tready && rsp_tlast,
      state_ff == ST_IDLE, "no idle after last byte")

endmodule

### tb/sv/tb_signed_int_to_radix_text.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_signed_int_to_radix_text
// Self-checking bench for the signed integer to radix text converter.
// A directed table covers reset state, decimal, hex and binary extremes,
// every kind of bad alphabet and register masking. Random phases then
// reprogram the alphabet and stream numbers with random stalls on both
// sides. Every text byte is checked against a predicted or typed-in text.
// ---------------------------------------------------------------------------
module tb_signed_int_to_radix_text;

   localparam int CYCLE_LIMIT  = 4000000;  // far above the slowest legal run
   localparam int DRAIN_CYCLES = 500;      // enough for a rejected request to finish
   localparam int HOLD_CYCLES  = 900;      // receiver hold-off, over two requests
   localparam int RANDOM_ITEMS = 240;

   // Register index with no register behind it
   localparam logic [sitrt_pkg::CSR_ADDR_W-1:0] CSR_UNUSED = 2'd3;

   // Alphabets: a string literal puts its last character in byte 0
   localparam logic [63:0] DIGITS_0_7 = "76543210";
   localparam logic [63:0] DIGITS_8_F = "FEDCBA98";

   typedef struct packed {
      logic [sitrt_pkg::CHAR_W-1:0] text_byte;
      logic                         last;
   } text_beat_type;

   typedef enum logic {ROW_WRITE, ROW_NUMBER} row_kind_type;

   typedef struct packed {
      row_kind_type                       kind;
      logic [sitrt_pkg::CSR_ADDR_W-1:0]   addr;
      logic [sitrt_pkg::CSR_DATA_W-1:0]   wdata;
      logic [sitrt_pkg::NUMBER_WIDTH-1:0] number;
      logic                               typed;   // text below is the expected output
      logic [95:0]                        text;    // right-aligned, leading NULs ignored
   } stim_row_type;

   logic                                      clock      = 1'b0;
   logic                                      reset      = 1'b1;
   logic                                      req_tvalid = 1'b0;
   logic                                      req_tready;
   logic signed [sitrt_pkg::NUMBER_WIDTH-1:0] req_tdata  = '0;
   logic                                      rsp_tvalid;
   logic                                      rsp_tready = 1'b0;
   logic [sitrt_pkg::CHAR_W-1:0]              rsp_tdata;
   logic                                      rsp_tlast;
   logic                                      csr_wr_en  = 1'b0;
   logic [sitrt_pkg::CSR_ADDR_W-1:0]          csr_addr   = '0;
   logic [sitrt_pkg::CSR_DATA_W-1:0]          csr_wdata  = '0;

   // Shadow copy of the configuration registers
   logic [sitrt_pkg::BASE_W-1:0]     radix_len  = '0;
   logic [sitrt_pkg::CSR_DATA_W-1:0] sym_low    = '0;
   logic [sitrt_pkg::CSR_DATA_W-1:0] sym_high   = '0;

   text_beat_type expected_text[$];
   text_beat_type seen_beat;
   stim_row_type  dir_rows[$];
   int            errors      = 0;
   int            cycle_count = 0;
   bit            burst_mode  = 1'b0;   // no idling on either side
   bit            hold_req    = 1'b0;   // ask the receiver for a long hold-off

   signed_int_to_radix_text uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [31:0] number
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [7:0] text_byte
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // 12 ns clock
   initial begin
      forever #6 clock = ~clock;
   end

   // Hold reset from time zero, release it once
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // Watchdog: end the run if it hangs
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // Mostly short gaps, now and then a long one
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 19);
      if (r < 12) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(20, 80);
   endfunction

   // ------------------------------------------------------------------
   // Text predictor
   // ------------------------------------------------------------------
   function automatic logic [sitrt_pkg::CHAR_W-1:0] alphabet_symbol(input int idx);
      logic [2*sitrt_pkg::CSR_DATA_W-1:0] all_syms;
      all_syms = {sym_high, sym_low};
      return all_syms[idx*sitrt_pkg::CHAR_W +: sitrt_pkg::CHAR_W];
   endfunction

   function automatic bit alphabet_valid();
      logic [sitrt_pkg::CHAR_W-1:0] s;
      if (radix_len < 2 || radix_len > sitrt_pkg::MAX_BASE) return 1'b0;
      for (int i = 0; i < radix_len; i++) begin
         s = alphabet_symbol(i);
         if (s == sitrt_pkg::CHAR_NUL || s == sitrt_pkg::CHAR_PLUS ||
             s == sitrt_pkg::CHAR_MINUS) return 1'b0;
         for (int j = i + 1; j < radix_len; j++)
            if (alphabet_symbol(j) == s) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Queue the text expected for one number under the current alphabet
   function automatic void predict_text(input logic [sitrt_pkg::NUMBER_WIDTH-1:0] number);
      logic [sitrt_pkg::MAG_WIDTH-1:0] mag;
      logic [sitrt_pkg::MAG_WIDTH-1:0] radix;
      logic [sitrt_pkg::CHAR_W-1:0]    digits [sitrt_pkg::MAG_WIDTH];
      logic                            neg;
      int                              nd;
      text_beat_type                   beat;
      if (!alphabet_valid()) return;
      radix = sitrt_pkg::MAG_WIDTH'(radix_len);
      neg   = number[sitrt_pkg::NUMBER_WIDTH-1];
      // magnitude one bit wider, so the most negative value survives
      mag   = neg ? ({1'b1, {sitrt_pkg::NUMBER_WIDTH{1'b0}}} - {1'b0, number})
                  : {1'b0, number};
      nd    = 0;
      do begin
         digits[nd] = alphabet_symbol(int'(mag % radix));
         mag        = mag / radix;
         nd++;
      end while (mag != 0);
      if (neg) begin
         beat.text_byte = sitrt_pkg::CHAR_MINUS;
         beat.last      = 1'b0;
         expected_text.push_back(beat);
      end
      while (nd > 0) begin
         nd--;
         beat.text_byte = digits[nd];
         beat.last      = (nd == 0);
         expected_text.push_back(beat);
      end
   endfunction

   // Queue a typed-in text, dropping leading NULs
   function automatic void push_typed(input logic [95:0] text);
      logic [sitrt_pkg::CHAR_W-1:0] chars[$];
      text_beat_type                beat;
      for (int i = 11; i >= 0; i--)
         if (text[i*sitrt_pkg::CHAR_W +: sitrt_pkg::CHAR_W] != sitrt_pkg::CHAR_NUL)
            chars.push_back(text[i*sitrt_pkg::CHAR_W +: sitrt_pkg::CHAR_W]);
      for (int i = 0; i < chars.size(); i++) begin
         beat.text_byte = chars[i];
         beat.last      = (i == chars.size() - 1);
         expected_text.push_back(beat);
      end
   endfunction

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------
   // Write one register; the enable drops for a cycle after each write
   task automatic write_reg(input logic [sitrt_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [sitrt_pkg::CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      case (addr)
         sitrt_pkg::CSR_BASE_LEN:     radix_len = data[sitrt_pkg::BASE_W-1:0];
         sitrt_pkg::CSR_SYMBOLS_LOW:  sym_low   = data;
         sitrt_pkg::CSR_SYMBOLS_HIGH: sym_high  = data;
         default: ;
      endcase
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one request and hold it until accepted
   task automatic offer_number(input logic [sitrt_pkg::NUMBER_WIDTH-1:0] number);
      req_tvalid <= 1'b1;
      req_tdata  <= number;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic idle_sender(input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering until every queued byte has come out
   task automatic wait_for_text();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_text.size() != 0);
   endtask

   // Block idle: all text out, then room for a silent request to finish
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_text.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Program a random alphabet; a corrupt one breaks one rule
   task automatic program_alphabet(input bit corrupt, input int forced_base);
      logic [sitrt_pkg::CHAR_W-1:0]       sym [sitrt_pkg::MAX_BASE];
      logic [sitrt_pkg::CHAR_W-1:0]       s;
      logic [2*sitrt_pkg::CSR_DATA_W-1:0] all_syms;
      logic [sitrt_pkg::CSR_DATA_W-1:0]   base_word;
      int                                 base;
      int                                 i;
      int                                 j;
      bit                                 clash;
      base = (forced_base != 0) ? forced_base : $urandom_range(2, sitrt_pkg::MAX_BASE);
      // unused bytes: anything
      for (i = 0; i < sitrt_pkg::MAX_BASE; i++) sym[i] = sitrt_pkg::CHAR_W'($urandom);
      for (i = 0; i < base; i++) begin
         do begin
            s     = sitrt_pkg::CHAR_W'($urandom_range(1, 255));
            clash = (s == sitrt_pkg::CHAR_PLUS) || (s == sitrt_pkg::CHAR_MINUS);
            for (j = 0; j < i; j++) if (sym[j] == s) clash = 1'b1;
         end while (clash);
         sym[i] = s;
      end
      if (corrupt) begin
         case ($urandom_range(0, 5))
            0: begin
               i      = $urandom_range(1, base - 1);
               j      = $urandom_range(0, i - 1);
               sym[i] = sym[j];
            end
            1: sym[$urandom_range(0, base - 1)] = sitrt_pkg::CHAR_PLUS;
            2: sym[$urandom_range(0, base - 1)] = sitrt_pkg::CHAR_MINUS;
            3: sym[$urandom_range(0, base - 1)] = sitrt_pkg::CHAR_NUL;
            4: base = $urandom_range(0, 1);
            default: base = $urandom_range(sitrt_pkg::MAX_BASE + 1, 31);
         endcase
      end
      for (i = 0; i < sitrt_pkg::MAX_BASE; i++)
         all_syms[i*sitrt_pkg::CHAR_W +: sitrt_pkg::CHAR_W] = sym[i];
      // random upper bits must be ignored by the radix register
      base_word                        = {$urandom, $urandom};
      base_word[sitrt_pkg::BASE_W-1:0] = base[sitrt_pkg::BASE_W-1:0];
      write_reg(sitrt_pkg::CSR_BASE_LEN, base_word);
      write_reg(sitrt_pkg::CSR_SYMBOLS_LOW, all_syms[sitrt_pkg::CSR_DATA_W-1:0]);
      write_reg(sitrt_pkg::CSR_SYMBOLS_HIGH,
                all_syms[2*sitrt_pkg::CSR_DATA_W-1:sitrt_pkg::CSR_DATA_W]);
   endtask

   function automatic logic [sitrt_pkg::NUMBER_WIDTH-1:0] random_number();
      logic [sitrt_pkg::NUMBER_WIDTH-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $urandom;
         4: v = $urandom_range(0, 40);
         5: v = 32'd0 - $urandom_range(1, 40);
         6: begin
            case ($urandom_range(0, 4))
               0: v = 32'd0;
               1: v = '1;
               2: v = 32'h8000_0000;
               3: v = 32'h7FFF_FFFF;
               default: v = 32'd1;
            endcase
         end
         default: begin
            v = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1)) v = 32'd0 - v;
         end
      endcase
      return v;
   endfunction

   // ------------------------------------------------------------------
   // Directed table
   // ------------------------------------------------------------------
   function automatic stim_row_type wr(input logic [sitrt_pkg::CSR_ADDR_W-1:0] addr,
                                       input logic [sitrt_pkg::CSR_DATA_W-1:0] data);
      stim_row_type r;
      r       = '0;
      r.kind  = ROW_WRITE;
      r.addr  = addr;
      r.wdata = data;
      return r;
   endfunction

   function automatic stim_row_type num(input logic [sitrt_pkg::NUMBER_WIDTH-1:0] n);
      stim_row_type r;
      r        = '0;
      r.kind   = ROW_NUMBER;
      r.number = n;
      return r;
   endfunction

   function automatic stim_row_type numt(input logic [sitrt_pkg::NUMBER_WIDTH-1:0] n,
                                         input logic [95:0] t);
      stim_row_type r;
      r       = num(n);
      r.typed = 1'b1;
      r.text  = t;
      return r;
   endfunction

   task automatic build_table();
      // reset state: radix 0, nothing comes out
      dir_rows.push_back(numt(32'd5, '0));
      dir_rows.push_back(numt(32'hFFFF_FFFF, '0));
      // decimal; a '-' among the unused bytes must not matter
      dir_rows.push_back(wr(sitrt_pkg::CSR_BASE_LEN, 64'd10));
      dir_rows.push_back(wr(sitrt_pkg::CSR_SYMBOLS_LOW, DIGITS_0_7));
      dir_rows.push_back(wr(sitrt_pkg::CSR_SYMBOLS_HIGH, 64'hFFFF_FFFF_FF2D_3938));
      dir_rows.push_back(numt(32'd0, "0"));
      dir_rows.push_back(numt(32'h7FFF_FFFF, "2147483647"));
      dir_rows.push_back(numt(32'h8000_0000, "-2147483648"));
      dir_rows.push_back(numt(32'hFFFF_FFFF, "-1"));
      dir_rows.push_back(numt(32'd9, "9"));
      dir_rows.push_back(numt(32'd10, "10"));
      dir_rows.push_back(num(32'd0 - 32'd1234567));
      // hex, full alphabet
      dir_rows.push_back(wr(sitrt_pkg::CSR_BASE_LEN, 64'd16));
      dir_rows.push_back(wr(sitrt_pkg::CSR_SYMBOLS_HIGH, DIGITS_8_F));
      dir_rows.push_back(numt(32'h7FFF_FFFF, "7FFFFFFF"));
      dir_rows.push_back(numt(32'h8000_0000, "-80000000"));
      dir_rows.push_back(num(32'hDEAD_BEEF));
      dir_rows.push_back(numt(32'd15, "F"));
      // binary: the longest texts
      dir_rows.push_back(wr(sitrt_pkg::CSR_BASE_LEN, 64'd2));
      dir_rows.push_back(num(32'h8000_0000));
      dir_rows.push_back(num(32'h7FFF_FFFF));
      dir_rows.push_back(numt(32'd0, "0"));
      // radix too small, too large, and the largest field value
      dir_rows.push_back(wr(sitrt_pkg::CSR_BASE_LEN, 64'd1));
      dir_rows.push_back(numt(32'd3, '0));
      dir_rows.push_back(wr(sitrt_pkg::CSR_BASE_LEN, 64'hFFFF_FFFF_FFFF_FFF1));
      dir_rows.push_back(numt(32'd3, '0));
      dir_rows.push_back(wr(sitrt_pkg::CSR_BASE_LEN, 64'hFFFF_FFFF_FFFF_FFFF));
      dir_rows.push_back(numt(32'd3, '0));
      // radix 3 through a masked write; then each bad symbol in turn
      dir_rows.push_back(wr(sitrt_pkg::CSR_BASE_LEN, 64'h23));
      dir_rows.push_back(wr(sitrt_pkg::CSR_SYMBOLS_LOW, 64'h0000_0000_0032_2B30));   // '+'
      dir_rows.push_back(numt(32'd5, '0));
      dir_rows.push_back(wr(sitrt_pkg::CSR_SYMBOLS_LOW, 64'h0000_0000_002D_3130));   // '-'
      dir_rows.push_back(numt(32'd5, '0));
      dir_rows.push_back(wr(sitrt_pkg::CSR_SYMBOLS_LOW, 64'h0000_0000_0032_3100));   // NUL
      dir_rows.push_back(numt(32'd5, '0));
      dir_rows.push_back(wr(sitrt_pkg::CSR_SYMBOLS_LOW, 64'h0000_0000_0030_3130));   // repeat
      dir_rows.push_back(numt(32'd5, '0));
      // good symbols "abc" with forbidden bytes parked above the radix
      dir_rows.push_back(wr(sitrt_pkg::CSR_SYMBOLS_LOW, 64'h2D2B_0000_0063_6261));
      dir_rows.push_back(numt(32'd0 - 32'd5, "-bc"));
      // a write to the unused index changes nothing
      dir_rows.push_back(wr(CSR_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF));
      dir_rows.push_back(numt(32'd7, "cb"));
   endtask

   // ------------------------------------------------------------------
   // Receiver: random stalls, plus one long hold-off on request
   // ------------------------------------------------------------------
   initial begin : receiver
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else begin
            gap = burst_mode ? 0 : idle_length();
            if (gap == 0) begin
               rsp_tready <= 1'b1;
               @(posedge clock);
            end else begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Checker: each accepted byte against the oldest expectation
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_text.size() == 0) begin
            errors++;
            $display("%0t: unexpected text byte: expected none, actual %h last %b",
                     $time, rsp_tdata, rsp_tlast);
         end else begin
            seen_beat = expected_text.pop_front();
            if (rsp_tdata !== seen_beat.text_byte) begin
               errors++;
               $display("%0t: text_byte mismatch: expected %h, actual %h",
                        $time, seen_beat.text_byte, rsp_tdata);
            end
            if (rsp_tlast !== seen_beat.last) begin
               errors++;
               $display("%0t: last mismatch: expected %b, actual %b",
                        $time, seen_beat.last, rsp_tlast);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      logic [sitrt_pkg::NUMBER_WIDTH-1:0] n;
      int  phase;
      int  count;
      int  valid_items;
      bit  corrupt;
      @(posedge clock);
      while (reset) @(posedge clock);

      // walk the directed table; writes wait for the block to go idle
      build_table();
      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_WRITE) begin
            settle();
            write_reg(dir_rows[i].addr, dir_rows[i].wdata);
         end else begin
            offer_number(dir_rows[i].number);
            if (dir_rows[i].typed) push_typed(dir_rows[i].text);
            else predict_text(dir_rows[i].number);
            idle_sender(idle_length());
         end
      end

      // random phases: first radix 16, then radix 2, then anything;
      // every fifth phase uses a broken alphabet
      valid_items = 0;
      phase       = 0;
      while (valid_items < RANDOM_ITEMS) begin
         corrupt = (phase % 5 == 3);
         settle();
         program_alphabet(corrupt,
                          (phase == 0) ? sitrt_pkg::MAX_BASE : (phase == 1) ? 2 : 0);
         if ($urandom_range(0, 3) == 0) write_reg(CSR_UNUSED, {$urandom, $urandom});
         burst_mode = (phase % 4 == 1);
         // long receiver hold-off while requests keep coming
         if (phase == 2) hold_req = 1'b1;
         count = corrupt ? 4 : $urandom_range(25, 40);
         for (int k = 0; k < count; k++) begin
            // pause the sender once per phase until the text has drained
            if (k == count / 2) wait_for_text();
            n = random_number();
            offer_number(n);
            predict_text(n);
            if (!corrupt) valid_items++;
            idle_sender(burst_mode ? 0 : idle_length());
         end
         phase++;
      end
      burst_mode = 1'b0;

      // drain, then give stray output a chance to show up
      settle();
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
